[rtl/rfam_pkg.sv]
`timescale 1ns / 1ps
package rfam_pkg;

  // Largest radius a register write may set.
  localparam int RFAM_MAX_RADIUS = 200;

  // Register map: byte address bit 2 selects the register index.
  localparam logic RFAM_REG_CIRCLE_RADIUS = 1'b0;

  localparam int RFAM_RADIUS_W = 8;
  localparam int RFAM_COORD_W  = 9;
  localparam int RFAM_SIDE_W   = 10;   // 2*(radius+1) before it is cut to the port width
  localparam int RFAM_SQR_W    = 18;   // square of a 9-bit offset
  localparam int RFAM_SUM_W    = 19;   // sum of two squares, at most 2*511*511
  localparam int RFAM_ROOT_W   = 20;   // partial root inside the digit recurrence
  localparam int RFAM_NUM_CELLS = 10;  // one cell per base-4 digit of the sum

  typedef struct packed {
    logic [RFAM_COORD_W-1:0] pixel_row;
    logic [RFAM_COORD_W-1:0] pixel_col;
  } pixel_word_t;

  typedef struct packed {
    logic [RFAM_RADIUS_W-1:0] alpha_value;
    logic [RFAM_COORD_W-1:0]  frame_side;
    logic                     outside_frame;
  } mask_word_t;

  // Word handed from one square-root cell to the next.
  typedef struct packed {
    logic [RFAM_SUM_W-1:0]    rem;
    logic [RFAM_ROOT_W-1:0]   root;
    logic [RFAM_RADIUS_W-1:0] radius;
    logic                     outside;
  } sqrt_word_t;

endpackage

[rtl/radial_falloff_alpha_mask.sv]
`timescale 1ns / 1ps
// Radial falloff alpha mask, one mask pixel per word.
//
// Pixel channel: pixel_valid / pixel_stall carry a word with pixel_row and
// pixel_col. Mask channel: mask_valid / mask_stall carry alpha_value,
// frame_side and outside_frame. A word moves at a clock edge where valid is
// high and stall is low. The APB port holds circle_radius at byte address 0.
//
// An accepted pixel passes to its mask word on the port through three front
// stages (center offsets, squares, sum of squares), ten cells of the
// digit-by-digit square root, one per base-4 digit of the 19-bit sum, and
// the output register that forms the alpha. A new pixel is accepted in every
// cycle while mask_stall is low, so throughput is then one word per clock.
//
// Reset clears every valid bit and sets the radius to 1. When the receiver
// stalls, each stage holds its word and a stage with no word still takes one
// from its neighbor, so the bubbles close up before pixel_stall is raised.
// Radius writes are expected only while no pixel is in flight.
module radial_falloff_alpha_mask #(
  parameter int MAX_RADIUS = rfam_pkg::RFAM_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel channel
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  rfam_pkg::pixel_word_t pixel,
  // mask channel
  output logic                  mask_valid,
  input  logic                  mask_stall,
  output rfam_pkg::mask_word_t  mask,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rfam_pkg::*;

  localparam int LAST = RFAM_NUM_CELLS - 1;

  // The radius register. A write of zero leaves it alone, and a value above
  // the limit is clamped to the limit.
  logic [RFAM_RADIUS_W-1:0] radius;
  logic [RFAM_RADIUS_W-1:0] wr_value;
  logic                     wr_en;

  assign pready   = 1'b1;
  assign wr_value = pwdata[RFAM_RADIUS_W-1:0];
  assign wr_en    = psel && penable && pwrite && (paddr[2] == RFAM_REG_CIRCLE_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RFAM_RADIUS_W'(1);
    end else if (wr_en && (wr_value != '0)) begin
      if ({2'b00, wr_value} > 10'(MAX_RADIUS)) begin
        radius <= RFAM_RADIUS_W'(MAX_RADIUS);
      end else begin
        radius <= wr_value;
      end
    end
  end

  always_comb begin
    if (paddr[2] == RFAM_REG_CIRCLE_RADIUS) begin
      prdata = {{(32 - RFAM_RADIUS_W){1'b0}}, radius};
    end else begin
      prdata = '0;
    end
  end

  // Front stages feed the first cell of the square-root chain.
  logic       front_ready;
  logic       front_valid;
  sqrt_word_t front_word;

  logic       cell_valid [RFAM_NUM_CELLS];
  logic       cell_ready [RFAM_NUM_CELLS];
  sqrt_word_t cell_word  [RFAM_NUM_CELLS];

  logic       out_ready;

  assign pixel_stall = !front_ready;

  rfam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pixel_valid),
    .up_word    (pixel),
    .radius     (radius),
    .up_ready   (front_ready),
    .valid      (front_valid),
    .word       (front_word),
    .down_ready (cell_ready[0])
  );

  for (genvar i = 0; i < RFAM_NUM_CELLS; i++) begin : g_cell
    logic       in_valid_i;
    sqrt_word_t in_word_i;
    logic       down_ready_i;

    if (i == 0) begin : g_head
      assign in_valid_i = front_valid;
      assign in_word_i  = front_word;
    end else begin : g_body
      assign in_valid_i = cell_valid[i-1];
      assign in_word_i  = cell_word[i-1];
    end

    if (i == LAST) begin : g_tail
      assign down_ready_i = out_ready;
    end else begin : g_link
      assign down_ready_i = cell_ready[i+1];
    end

    rfam_sqrt_cell #(
      .STEP (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (in_valid_i),
      .up_word    (in_word_i),
      .up_ready   (cell_ready[i]),
      .valid      (cell_valid[i]),
      .word       (cell_word[i]),
      .down_ready (down_ready_i)
    );
  end

  // Output register: the root is the integer distance, and the alpha is the
  // radius minus that distance inside the circle.
  sqrt_word_t               fin;
  logic [RFAM_SIDE_W-1:0]   fin_side;
  logic                     fin_inside;
  mask_word_t               mask_next;

  always_comb begin
    fin        = cell_word[LAST];
    fin_side   = {({1'b0, fin.radius} + RFAM_COORD_W'(1)), 1'b0};
    fin_inside = !fin.outside &&
                 (fin.root <= {{(RFAM_ROOT_W - RFAM_RADIUS_W){1'b0}}, fin.radius});
    mask_next.frame_side    = fin_side[RFAM_COORD_W-1:0];
    mask_next.outside_frame = fin.outside;
    if (fin_inside) begin
      mask_next.alpha_value = fin.radius - fin.root[RFAM_RADIUS_W-1:0];
    end else begin
      mask_next.alpha_value = '0;
    end
  end

  assign out_ready = !mask_valid || !mask_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
    end else if (out_ready) begin
      mask_valid <= cell_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && cell_valid[LAST]) begin
      mask <= mask_next;
    end
  end

  // The clamp and the zero-write rule keep the radius in its legal range.
  a_radius_range: assert property (@(posedge clk) disable iff (rst)
    (radius != '0) && ({2'b00, radius} <= 10'(MAX_RADIUS)))
    else $error("radius register left its legal range");

  // A pixel outside the frame never carries a nonzero alpha.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    mask_valid && mask.outside_frame |-> mask.alpha_value == '0)
    else $error("outside pixel has nonzero alpha");

  // The alpha can never exceed the radius it was formed from.
  a_alpha_bound: assert property (@(posedge clk) disable iff (rst)
    mask_valid |-> mask.alpha_value <= radius)
    else $error("alpha above radius");

  // A word taken from the last cell shows up on the mask port next cycle.
  a_last_cell_moves: assert property (@(posedge clk) disable iff (rst)
    cell_valid[LAST] && out_ready |=> mask_valid)
    else $error("result from the square-root chain was lost");

endmodule

[rtl/rfam_front.sv]
`timescale 1ns / 1ps
module rfam_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  input  rfam_pkg::pixel_word_t               up_word,
  input  logic [rfam_pkg::RFAM_RADIUS_W-1:0]  radius,
  output logic                                up_ready,
  output logic                                valid,
  output rfam_pkg::sqrt_word_t                word,
  input  logic                                down_ready
);
  import rfam_pkg::*;

  // Stage a: offsets from the center and the frame test.
  logic                     a_valid;
  logic [RFAM_COORD_W-1:0]  a_dx;
  logic [RFAM_COORD_W-1:0]  a_dy;
  logic [RFAM_RADIUS_W-1:0] a_radius;
  logic                     a_outside;
  // Stage b: the two squares.
  logic                     b_valid;
  logic [RFAM_SQR_W-1:0]    b_dx2;
  logic [RFAM_SQR_W-1:0]    b_dy2;
  logic [RFAM_RADIUS_W-1:0] b_radius;
  logic                     b_outside;

  logic                     a_ready;
  logic                     b_ready;
  logic                     c_ready;

  logic [RFAM_COORD_W-1:0]  centre;
  logic [RFAM_SIDE_W-1:0]   side;
  logic [RFAM_COORD_W-1:0]  dx_next;
  logic [RFAM_COORD_W-1:0]  dy_next;
  logic                     outside_next;

  always_comb begin
    centre = {1'b0, radius} + RFAM_COORD_W'(1);
    side   = {centre, 1'b0};
    outside_next = ({1'b0, up_word.pixel_row} >= side) ||
                   ({1'b0, up_word.pixel_col} >= side);
    if (up_word.pixel_row >= centre) begin
      dx_next = up_word.pixel_row - centre;
    end else begin
      dx_next = centre - up_word.pixel_row;
    end
    if (up_word.pixel_col >= centre) begin
      dy_next = up_word.pixel_col - centre;
    end else begin
      dy_next = centre - up_word.pixel_col;
    end
  end

  assign c_ready  = !valid || down_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      valid   <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= up_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_dx      <= dx_next;
      a_dy      <= dy_next;
      a_radius  <= radius;
      a_outside <= outside_next;
    end
    if (b_ready && a_valid) begin
      b_dx2     <= RFAM_SQR_W'(a_dx) * RFAM_SQR_W'(a_dx);
      b_dy2     <= RFAM_SQR_W'(a_dy) * RFAM_SQR_W'(a_dy);
      b_radius  <= a_radius;
      b_outside <= a_outside;
    end
    if (c_ready && b_valid) begin
      word.rem     <= {1'b0, b_dx2} + {1'b0, b_dy2};
      word.root    <= '0;
      word.radius  <= b_radius;
      word.outside <= b_outside;
    end
  end

endmodule

[rtl/rfam_sqrt_cell.sv]
`timescale 1ns / 1ps
module rfam_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  rfam_pkg::sqrt_word_t up_word,
  output logic                 up_ready,
  output logic                 valid,
  output rfam_pkg::sqrt_word_t word,
  input  logic                 down_ready
);
  import rfam_pkg::*;

  // Each cell settles one base-4 digit, the most significant one first.
  localparam int SHIFT = 2 * (RFAM_NUM_CELLS - 1 - STEP);
  localparam logic [RFAM_ROOT_W-1:0] BIT = {{(RFAM_ROOT_W-1){1'b0}}, 1'b1} << SHIFT;

  logic [RFAM_ROOT_W:0] trial;
  sqrt_word_t           word_next;

  always_comb begin
    trial     = {1'b0, up_word.root} + {1'b0, BIT};
    word_next = up_word;
    if ({{(RFAM_ROOT_W + 1 - RFAM_SUM_W){1'b0}}, up_word.rem} >= trial) begin
      word_next.rem  = up_word.rem - trial[RFAM_SUM_W-1:0];
      word_next.root = (up_word.root >> 1) + BIT;
    end else begin
      word_next.root = up_word.root >> 1;
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= word_next;
    end
  end

endmodule

[test/tb_radial_falloff_alpha_mask.sv]
`timescale 1ns / 1ps

module tb_radial_falloff_alpha_mask;
  import rfam_pkg::*;

  // Keeps the predicted radius and the mask words that are still owed by the block.
  class alpha_mask_scoreboard;
    int unsigned radius;
    mask_word_t  owed_masks[$];
    int          errors;

    function new();
      radius = 1;
      errors = 0;
    endfunction

    // Applies a register write the way the block should take it.
    function void apply_write(logic [2:0] addr, logic [31:0] data);
      int unsigned v;
      if (addr[2] != RFAM_REG_CIRCLE_RADIUS) return;
      v = 32'(data[RFAM_RADIUS_W-1:0]);
      if (v == 0) return;
      if (v > RFAM_MAX_RADIUS) v = RFAM_MAX_RADIUS;
      radius = v;
    endfunction

    function mask_word_t predict_mask(pixel_word_t p);
      int unsigned row, col, center, side, dx, dy, dist_sq, dist_root;
      mask_word_t  m;
      row = 32'(p.pixel_row);
      col = 32'(p.pixel_col);
      center = radius + 1;
      side = 2 * center;
      m.frame_side = RFAM_COORD_W'(side);
      m.alpha_value = '0;
      m.outside_frame = 1'b0;
      if (row >= side || col >= side) begin
        m.outside_frame = 1'b1;
      end else begin
        dx = (row >= center) ? row - center : center - row;
        dy = (col >= center) ? col - center : center - col;
        dist_sq = dx * dx + dy * dy;
        // Largest integer whose square does not exceed the squared distance.
        dist_root = 0;
        while ((dist_root + 1) * (dist_root + 1) <= dist_sq) dist_root++;
        if (dist_root <= radius) m.alpha_value = RFAM_RADIUS_W'(radius - dist_root);
      end
      return m;
    endfunction

    function void note_pixel(pixel_word_t p);
      owed_masks.push_back(predict_mask(p));
    endfunction

    function void check_mask(mask_word_t got);
      mask_word_t want;
      if (owed_masks.size() == 0) begin
        $display("%0t: unexpected mask word, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = owed_masks.pop_front();
      if (got.alpha_value !== want.alpha_value) begin
        $display("%0t: alpha_value mismatch, expected %0d, actual %0d",
                 $time, want.alpha_value, got.alpha_value);
        errors++;
      end
      if (got.frame_side !== want.frame_side) begin
        $display("%0t: frame_side mismatch, expected %0d, actual %0d",
                 $time, want.frame_side, got.frame_side);
        errors++;
      end
      if (got.outside_frame !== want.outside_frame) begin
        $display("%0t: outside_frame mismatch, expected %0b, actual %0b",
                 $time, want.outside_frame, got.outside_frame);
        errors++;
      end
    endfunction
  endclass

  // The run is cut off here; a correct run needs a small fraction of this.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 64;
  localparam int NUM_PHASES  = 7;
  localparam int LONG_HOLD   = 60;
  // The radius register and an address that decodes to no register.
  localparam logic [2:0] RADIUS_ADDR = {RFAM_REG_CIRCLE_RADIUS, 2'b00};
  localparam logic [2:0] SPARE_ADDR  = {~RFAM_REG_CIRCLE_RADIUS, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pixel_word_t pixel = '0;
  logic        mask_valid;
  logic        mask_stall = 1'b0;
  mask_word_t  mask;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alpha_mask_scoreboard sb;

  // Percent chance per word or cycle that a burst of idling starts on each side.
  int  gap_pct = 0;
  int  stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit  hold_req = 1'b0;
  int  cycle_count = 0;

  radial_falloff_alpha_mask i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .mask_valid  (mask_valid),
    .mask_stall  (mask_stall),
    .mask        (mask),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every mask word that moves is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && mask_valid && !mask_stall) sb.check_mask(mask);
  end

  // Receiver side. Stall comes in bursts of random length, and once on request
  // the receiver holds off long enough for the pipeline to fill and push back.
  initial begin : mask_receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        mask_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        mask_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst_left = $urandom_range(1, 8) - 1;
        mask_stall <= 1'b1;
      end else begin
        mask_stall <= 1'b0;
      end
    end
  end

  // All stimulus tasks start and end at a falling edge. A word is offered,
  // possibly after an idle burst, and held until the block takes it.
  task automatic send_pixel(input logic [8:0] row, input logic [8:0] col);
    pixel_word_t w;
    w.pixel_row = row;
    w.pixel_col = col;
    if ($urandom_range(0, 99) < gap_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= w;
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel(w);
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted mask word has come out, so the
  // pipeline is empty and a radius write cannot affect a pixel in flight.
  task automatic drain_pixels();
    pixel_valid <= 1'b0;
    while (sb.owed_masks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // The bus is left idle after each access.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_write(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Reads the radius back and compares it with the predicted value.
  task automatic reg_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= RADIUS_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[RFAM_RADIUS_W-1:0] !== RFAM_RADIUS_W'(sb.radius)) begin
      $display("%0t: circle_radius readback mismatch, expected %0d, actual %0d",
               $time, sb.radius, prdata[RFAM_RADIUS_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Most random pixels fall inside the current frame, where the distance math
  // lives; the rest use the full coordinate range and mostly land outside.
  task automatic send_random_pixel();
    int unsigned side;
    side = 2 * (sb.radius + 1);
    if ($urandom_range(0, 99) < 80)
      send_pixel(9'($urandom_range(0, side - 1)), 9'($urandom_range(0, side - 1)));
    else
      send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
  endtask

  initial begin : stimulus
    logic [31:0] radius_word;
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset radius of 1: the center, the frame corners,
    // the first rows and columns outside, and the largest coordinates.
    gap_pct = 20;
    stall_pct = 20;
    reg_check();
    send_pixel(9'd2, 9'd2);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd3, 9'd3);
    send_pixel(9'd3, 9'd2);
    send_pixel(9'd4, 9'd0);
    send_pixel(9'd0, 9'd4);
    send_pixel(9'd511, 9'd511);
    drain_pixels();

    // A zero write is rejected and a write to an unused address is ignored,
    // so the radius must still be 1.
    reg_write(RADIUS_ADDR, 32'd0);
    reg_write(SPARE_ADDR, 32'd77);
    reg_check();
    send_pixel(9'd1, 9'd2);
    send_pixel(9'd3, 9'd0);
    drain_pixels();

    // Only the low byte counts: 0x1FF becomes 255 and clamps to the maximum.
    reg_write(RADIUS_ADDR, 32'h0000_01FF);
    reg_check();
    send_pixel(9'd201, 9'd201);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd401, 9'd401);
    send_pixel(9'd201, 9'd1);
    send_pixel(9'd201, 9'd0);
    send_pixel(9'd1, 9'd201);
    send_pixel(9'd402, 9'd0);
    send_pixel(9'd0, 9'd402);
    send_pixel(9'd257, 9'd144);
    drain_pixels();

    // Low byte of 0x100 is zero, so this write is rejected as well.
    reg_write(RADIUS_ADDR, 32'h0000_0100);
    reg_check();
    send_pixel(9'd200, 9'd202);
    send_pixel(9'd511, 9'd0);
    drain_pixels();

    // Random phases, each with its own radius. The first two cover the
    // extremes, one uses a full 32-bit write, and the last runs without idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: radius_word = 32'd1;
        1: radius_word = 32'd255;
        2: radius_word = $urandom_range(2, 199);
        3: radius_word = $urandom;
        4: radius_word = 32'd200;
        5: radius_word = $urandom_range(1, 50);
        default: radius_word = $urandom_range(1, 200);
      endcase
      reg_write(RADIUS_ADDR, radius_word);
      reg_check();
      case (phase)
        1: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        NUM_PHASES - 1: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        default: begin
          gap_pct = $urandom_range(5, 30);
          stall_pct = $urandom_range(5, 30);
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // A quarter into one phase the receiver holds off for a long time while
        // words keep coming; midway into another the sender lets the pipe empty.
        if (phase == 2 && n == PHASE_WORDS / 4) hold_req = 1'b1;
        if (phase == 4 && n == PHASE_WORDS / 2) drain_pixels();
        send_random_pixel();
      end
      drain_pixels();
    end

    // Let any stray output show up before the verdict.
    repeat (30) @(posedge clk);
    if (sb.owed_masks.size() != 0) begin
      $display("%0t: %0d mask words expected but never seen", $time, sb.owed_masks.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rfam_pkg.sv
rtl/rfam_front.sv
rtl/rfam_sqrt_cell.sv
rtl/radial_falloff_alpha_mask.sv
test/tb_radial_falloff_alpha_mask.sv
